// ===== src/adc_pkg.sv =====
// ----------------------------------------------------------------------------
// adc_pkg: shared types and constants of the dynamics compressor
// Register indexes, reset values, sequencer states and the structs that pass
// between the register file, the sequencer and the shared multiplier.
// ----------------------------------------------------------------------------
package adc_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 15;
  localparam int COEF_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int ENV_W    = 31;   // Q0.31 envelope, never above 32767 << 16
  localparam int IDX_W    = 8;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 49;   // signed 32 x signed 17
  localparam int DIV_STEPS = 16;  // one quotient bit per step

  // register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [IDX_W-1:0] REG_INV_RATIO = 8'd1;
  localparam logic [IDX_W-1:0] REG_ATTACK    = 8'd2;
  localparam logic [IDX_W-1:0] REG_RELEASE   = 8'd3;

  // reset values
  localparam logic [THR_W-1:0]  RST_THRESHOLD = 15'd22938;
  localparam logic [COEF_W-1:0] RST_INV_RATIO = 16'd8192;
  localparam logic [COEF_W-1:0] RST_ATTACK    = 16'd65042;
  localparam logic [COEF_W-1:0] RST_RELEASE   = 16'd65521;

  localparam logic [GAIN_W-1:0]   UNITY_GAIN = 16'h8000;
  localparam logic [THR_W-1:0]    MAX_LEVEL  = 15'h7FFF;
  localparam logic [ENV_W-1:0]    MAX_ENV    = {MAX_LEVEL, 16'h0000};
  localparam logic [SAMPLE_W-1:0] MOST_NEG   = 16'h8000;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_THR_CMP,
    ST_THR_MUL,
    ST_TARGET,
    ST_DIV,
    ST_SCALE_MUL,
    ST_SCALE,
    ST_OUT
  } state_t;

  // configuration as seen by the sequencer
  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [COEF_W-1:0] inverse_ratio;
    logic [COEF_W-1:0] attack_coefficient;
    logic [COEF_W-1:0] release_coefficient;
  } cfg_t;

  // operands for the shared multiplier
  typedef struct packed {
    logic signed [31:0] a;
    logic [COEF_W-1:0]  b;
  } mul_req_t;

endpackage

// ===== src/adc_in_if.sv =====
// ----------------------------------------------------------------------------
// adc_in_if: sample input channel
// Valid/ready channel carrying one audio sample and its buffer-end mark.
// ----------------------------------------------------------------------------
interface adc_in_if
  import adc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

// ===== src/adc_out_if.sv =====
// ----------------------------------------------------------------------------
// adc_out_if: result output channel
// Valid/ready channel carrying the compressed sample, its gain and the mark.
// ----------------------------------------------------------------------------
interface adc_out_if
  import adc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [GAIN_W-1:0]          gain_out;
  logic                       block_end_out;

  modport source (output valid, output sample_out, output gain_out,
                  output block_end_out, input ready);
  modport sink   (input valid, input sample_out, input gain_out,
                  input block_end_out, output ready);
endinterface

// ===== src/adc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// adc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface adc_cfg_if
  import adc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/adc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// adc_cfg_regs: configuration register file
// Four write-only registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module adc_cfg_regs
  import adc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  adc_cfg_if.sink     cfg_if,
  output cfg_t        cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg_o        = cfg_r;

  // register decode, low bits of the data word kept
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_THRESHOLD: cfg_nxt.threshold           = cfg_if.data[THR_W-1:0];
        REG_INV_RATIO: cfg_nxt.inverse_ratio       = cfg_if.data;
        REG_ATTACK:    cfg_nxt.attack_coefficient  = cfg_if.data;
        REG_RELEASE:   cfg_nxt.release_coefficient = cfg_if.data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold           <= RST_THRESHOLD;
      cfg_r.inverse_ratio       <= RST_INV_RATIO;
      cfg_r.attack_coefficient  <= RST_ATTACK;
      cfg_r.release_coefficient <= RST_RELEASE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/adc_mul.sv =====
// ----------------------------------------------------------------------------
// adc_mul: shared multiplier
// Signed 32 x unsigned 16 multiply with a registered product; the sequencer
// reads the product in the cycle after it presents the operands.
// ----------------------------------------------------------------------------
module adc_mul
  import adc_pkg::*;
(
  input  logic                     clk,
  input  mul_req_t                 req_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  // b is unsigned: widen with a zero sign bit
  assign prod_nxt = PROD_W'(req_i.a * $signed({1'b0, req_i.b}));
  assign prod_o   = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== src/adc_core.sv =====
// ----------------------------------------------------------------------------
// adc_core: compressor sequencer
// Walks one sample through envelope update, threshold test, and (above
// threshold only) target gain and a restoring divide of one quotient bit per
// cycle, then sample scaling, using the shared multiplier for every product.
// ----------------------------------------------------------------------------
module adc_core
  import adc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  adc_in_if.sink                   in_if,
  adc_out_if.source                out_if,
  input  cfg_t                     cfg_i,
  output mul_req_t                 mul_req_o,
  input  logic signed [PROD_W-1:0] mul_prod_i
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  state_t state_r, state_nxt;

  // working registers
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic                       blk_r, blk_nxt;
  logic [ENV_W-1:0]           lvl_r, lvl_nxt;
  logic [ENV_W-1:0]           env_r, env_nxt;
  logic [ENV_W-1:0]           diff_r, diff_nxt;
  logic                       rise_r, rise_nxt;
  logic [ENV_W:0]             rem_r, rem_nxt;
  logic [GAIN_W-1:0]          gain_r, gain_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;

  // output word register
  logic                       ovld_r, ovld_nxt;
  logic signed [SAMPLE_W-1:0] osmp_r, osmp_nxt;
  logic [GAIN_W-1:0]          ogain_r, ogain_nxt;
  logic                       oblk_r, oblk_nxt;

  logic [THR_W-1:0]  mag;
  logic [ENV_W-1:0]  lvl_in;
  logic              rise_in;
  logic [ENV_W-1:0]  thr31;
  logic [COEF_W-1:0] inv_eff;
  logic [ENV_W:0]    div_sub;
  logic              div_bit;

  // saturated magnitude of the incoming word
  always_comb begin
    if (in_if.sample_in == MOST_NEG) begin
      mag = MAX_LEVEL;
    end else if (in_if.sample_in[SAMPLE_W-1]) begin
      mag = THR_W'(-in_if.sample_in);
    end else begin
      mag = in_if.sample_in[THR_W-1:0];
    end
  end

  assign lvl_in  = {mag, 16'h0000};
  assign rise_in = lvl_in > env_r;
  assign thr31   = {cfg_i.threshold, 16'h0000};
  // inverse ratio at or above unity acts as unity
  assign inv_eff = cfg_i.inverse_ratio[COEF_W-1] ? UNITY_GAIN : cfg_i.inverse_ratio;

  // restoring divide step
  assign div_sub = rem_r - {1'b0, env_r};
  assign div_bit = rem_r >= {1'b0, env_r};

  // multiplier operand select
  always_comb begin
    mul_req_o.a = {1'b0, diff_r};
    mul_req_o.b = rise_r ? cfg_i.attack_coefficient : cfg_i.release_coefficient;
    if (state_r == ST_THR_MUL) begin
      mul_req_o.b = inv_eff;
    end else if (state_r == ST_SCALE_MUL) begin
      mul_req_o.a = 32'(x_r);
      mul_req_o.b = gain_r;
    end
  end

  assign in_if.ready          = (state_r == ST_IDLE);
  assign out_if.valid         = ovld_r;
  assign out_if.sample_out    = osmp_r;
  assign out_if.gain_out      = ogain_r;
  assign out_if.block_end_out = oblk_r;

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    blk_nxt   = blk_r;
    lvl_nxt   = lvl_r;
    env_nxt   = env_r;
    diff_nxt  = diff_r;
    rise_nxt  = rise_r;
    rem_nxt   = rem_r;
    gain_nxt  = gain_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r && !out_if.ready;
    osmp_nxt  = osmp_r;
    ogain_nxt = ogain_r;
    oblk_nxt  = oblk_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          x_nxt     = in_if.sample_in;
          blk_nxt   = in_if.block_end;
          lvl_nxt   = lvl_in;
          rise_nxt  = rise_in;
          diff_nxt  = rise_in ? lvl_in - env_r : env_r - lvl_in;
          state_nxt = ST_ENV_MUL;
        end
      end
      ST_ENV_MUL: state_nxt = ST_ENV_UPD;
      ST_ENV_UPD: begin
        env_nxt   = rise_r ? lvl_r - mul_prod_i[46:16] : lvl_r + mul_prod_i[46:16];
        state_nxt = ST_THR_CMP;
      end
      ST_THR_CMP: begin
        diff_nxt = env_r - thr31;
        if (env_r > thr31) begin
          state_nxt = ST_THR_MUL;
        end else begin
          gain_nxt  = UNITY_GAIN;
          state_nxt = ST_SCALE_MUL;
        end
      end
      ST_THR_MUL: state_nxt = ST_TARGET;
      ST_TARGET: begin
        rem_nxt   = {1'b0, thr31} + {1'b0, mul_prod_i[45:15]};
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // quotient bits enter from the bottom, MSB first
        gain_nxt = {gain_r[GAIN_W-2:0], div_bit};
        rem_nxt  = div_bit ? {div_sub[ENV_W-1:0], 1'b0} : {rem_r[ENV_W-1:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SCALE_MUL;
        end
      end
      ST_SCALE_MUL: state_nxt = ST_SCALE;
      ST_SCALE: begin
        // arithmetic shift right by 15, floor toward minus infinity;
        // kept in the sample register, the output word may still be waiting
        x_nxt     = mul_prod_i[30:15];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_r || out_if.ready) begin
          ovld_nxt  = 1'b1;
          osmp_nxt  = x_r;
          ogain_nxt = gain_r;
          oblk_nxt  = blk_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      env_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      env_r   <= env_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    blk_r   <= blk_nxt;
    lvl_r   <= lvl_nxt;
    diff_r  <= diff_nxt;
    rise_r  <= rise_nxt;
    rem_r   <= rem_nxt;
    gain_r  <= gain_nxt;
    cnt_r   <= cnt_nxt;
    osmp_r  <= osmp_nxt;
    ogain_r <= ogain_nxt;
    oblk_r  <= oblk_nxt;
  end

`ifndef SYNTH
  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.gain_out <= UNITY_GAIN)
    else $error("gain above unity");

  a_env_max: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= MAX_ENV)
    else $error("envelope above full scale");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < {env_r, 1'b0})
    else $error("divider remainder out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("accepted a word while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && ovld_r && !out_if.ready) |=> state_r == ST_OUT)
    else $error("result dropped while output stalled");
`endif

endmodule

// ===== src/audio_dynamics_compressor.sv =====
// ----------------------------------------------------------------------------
// audio_dynamics_compressor: feed-forward peak compressor, top level
// Channel  | dir | handshake             | payload
// in_if    | in  | valid/ready           | sample_in[15:0] signed, block_end
// out_if   | out | valid/ready           | sample_out[15:0] signed, gain_out[15:0],
//          |     |                       | block_end_out
// cfg_if   | in  | valid/ready (always 1)| index[7:0], data[15:0]
//
// A sample above threshold goes through a restoring divide before scaling;
// a sample at or below threshold skips the divide and is scaled at unity gain.
// Reset (rst_n low, synchronous) restores register defaults and clears the
// envelope. A finished word waits in the output register; a new sample is
// taken meanwhile, and the sequencer holds its last step while out_if stalls.
// ----------------------------------------------------------------------------
module audio_dynamics_compressor
  import adc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  adc_in_if.sink     in_if,
  adc_out_if.source  out_if,
  adc_cfg_if.sink    cfg_if
);

  cfg_t                     cfg;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] mul_prod;

  adc_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_if(cfg_if),
    .cfg_o (cfg)
  );

  adc_mul u_mul (
    .clk   (clk),
    .req_i (mul_req),
    .prod_o(mul_prod)
  );

  adc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_i     (cfg),
    .mul_req_o (mul_req),
    .mul_prod_i(mul_prod)
  );

endmodule
